// ===== src/smseq_pkg.sv =====
// shared constants and lookup tables of the stepper microstep sequencer
package smseq_pkg;

    localparam int PWM_PERIOD   = 1000;
    localparam int MICROSTEPS   = 16;
    localparam int SPEED_LEVELS = 251;
    localparam int CYCLE_STEPS  = 4 * MICROSTEPS;

    localparam int STEP_W   = $clog2(CYCLE_STEPS);
    localparam int POS_W    = $clog2(MICROSTEPS);
    localparam int TBL_W    = $clog2(MICROSTEPS + 1);
    localparam int LEVEL_W  = $clog2(SPEED_LEVELS);
    localparam int DUTY_W   = 10;
    localparam int PCT_W    = 7;
    localparam int INC_W    = 3;
    localparam int PRESC_W  = 11;
    localparam int SPEED_W  = 9;
    localparam int PROD_W   = DUTY_W + PCT_W;

    localparam int FAST_MARGIN    = 10;
    localparam int END_OFFSET     = 2;
    localparam int PERCENT_FULL   = 100;
    localparam int FAST_LEVEL     = 51;
    localparam int START_INC      = 1;
    localparam int FAST_INC       = 4;
    localparam int RESET_PRESCALE = 1250;
    localparam int RESET_PCT_COS  = 10;

    // divide by 100 as multiply by reciprocal, exact for products up to 100000
    localparam int DIV100_SHIFT = 24;
    localparam int DIV100_MUL_W = 18;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL =
        DIV100_MUL_W'((64'd1 << DIV100_SHIFT) / PERCENT_FULL + 1);

    // configuration register indexes
    localparam logic CFG_DECAY_PCT_SINE   = 1'b0;
    localparam logic CFG_DECAY_PCT_COSINE = 1'b1;

    // quarter wave sine, duty counts for angle i*pi/(2*MICROSTEPS)
    localparam logic [DUTY_W-1:0] SINE_TABLE [MICROSTEPS+1] = '{
        10'd0,   10'd98,  10'd195, 10'd290, 10'd383, 10'd471, 10'd556, 10'd634,
        10'd707, 10'd773, 10'd831, 10'd882, 10'd924, 10'd957, 10'd981, 10'd995,
        10'd1000
    };

    // speed curve: ticks per microstep advance for each speed level
    localparam logic [PRESC_W-1:0] SPEED_PRESCALE [SPEED_LEVELS] = '{
        11'd1250, 11'd1250, 11'd625, 11'd416, 11'd312, 11'd250, 11'd208, 11'd178, 11'd156, 11'd138,
        11'd125, 11'd113, 11'd104, 11'd96, 11'd89, 11'd83, 11'd78, 11'd73, 11'd69, 11'd65,
        11'd62, 11'd59, 11'd56, 11'd54, 11'd52, 11'd50, 11'd48, 11'd46, 11'd44, 11'd43,
        11'd41, 11'd40, 11'd39, 11'd37, 11'd36, 11'd35, 11'd34, 11'd33, 11'd32, 11'd32,
        11'd31, 11'd30, 11'd29, 11'd29, 11'd28, 11'd27, 11'd27, 11'd26, 11'd26, 11'd25,
        11'd25,
        11'd98, 11'd96, 11'd94, 11'd92, 11'd90, 11'd89, 11'd87, 11'd86, 11'd84, 11'd83,
        11'd81, 11'd80, 11'd79, 11'd78, 11'd76, 11'd75, 11'd74, 11'd73, 11'd72, 11'd71,
        11'd70, 11'd69, 11'd68, 11'd67, 11'd66, 11'd65, 11'd64, 11'd64, 11'd63, 11'd62,
        11'd61, 11'd60, 11'd60, 11'd59, 11'd58, 11'd58, 11'd57, 11'd56, 11'd56, 11'd55,
        11'd54, 11'd54, 11'd53, 11'd53, 11'd52, 11'd52, 11'd51, 11'd51, 11'd50, 11'd50,
        11'd49, 11'd49, 11'd48, 11'd48, 11'd47, 11'd47, 11'd46, 11'd46, 11'd45, 11'd45,
        11'd45, 11'd44, 11'd44, 11'd43, 11'd43, 11'd43, 11'd42, 11'd42, 11'd42, 11'd41,
        11'd41, 11'd40, 11'd40, 11'd40, 11'd40, 11'd39, 11'd39, 11'd39, 11'd38, 11'd38,
        11'd38, 11'd37, 11'd37, 11'd37, 11'd37, 11'd36, 11'd36, 11'd36, 11'd35, 11'd35,
        11'd35, 11'd35, 11'd34, 11'd34, 11'd34, 11'd34, 11'd34, 11'd33, 11'd33, 11'd33,
        11'd33, 11'd32, 11'd32, 11'd32, 11'd32, 11'd32, 11'd31, 11'd31, 11'd31, 11'd31,
        11'd31, 11'd30, 11'd30, 11'd30, 11'd30, 11'd30, 11'd29, 11'd29, 11'd29, 11'd29,
        11'd29, 11'd29, 11'd28, 11'd28, 11'd28, 11'd28, 11'd28, 11'd28, 11'd27, 11'd27,
        11'd27, 11'd27, 11'd27, 11'd27, 11'd27, 11'd26, 11'd26, 11'd26, 11'd26, 11'd26,
        11'd26, 11'd26, 11'd25, 11'd25, 11'd25, 11'd25, 11'd25, 11'd25, 11'd25, 11'd25,
        11'd24, 11'd24, 11'd24, 11'd24, 11'd24, 11'd24, 11'd24, 11'd24, 11'd23, 11'd23,
        11'd23, 11'd23, 11'd23, 11'd23, 11'd23, 11'd23, 11'd23, 11'd22, 11'd22, 11'd22,
        11'd22, 11'd22, 11'd22, 11'd22, 11'd22, 11'd22, 11'd22, 11'd21, 11'd21, 11'd21,
        11'd21, 11'd21, 11'd21, 11'd21, 11'd21, 11'd21, 11'd21, 11'd21, 11'd20, 11'd20,
        11'd20, 11'd20, 11'd20, 11'd20, 11'd20, 11'd20, 11'd20, 11'd20, 11'd20, 11'd20
    };

endpackage

// ===== src/stepper_microstep_sequencer_core.sv =====
// stepper microstep sequencer: sine/cosine indexer with per-leg decay windows
//
// one request on s_ per pwm period tick, carrying a signed target speed
// (sign is direction, zero stops stepping). each accepted request yields
// exactly one result on m_: the quadrant and microstep index before this
// tick's step, the duty of both phases from the quarter wave table and the
// decay window each phase's bridge leg stored on its previous visit.
// decay percent registers are written through cfg_wr_en/cfg_index/cfg_wdata,
// which the user must do only while no request is in flight; the block has
// no check for it. values above 100 act as 100. the result is registered and
// appears in the cycle after acceptance. throughput: one request per cycle
// while m_ready is high, set by the single update pass from the state
// registers through the table reads and one multiply into the result and
// leg window registers. the result register frees as its result is taken, so
// s_ready stays high while m_ready is high; when the receiver stalls the
// result holds and s_ready drops until it is taken.
// reset (aresetn low, synchronous) returns the index, prescaler, speed curve
// latches, leg windows and registers to their power-up values at once.
module stepper_microstep_sequencer_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic                                    cfg_index,
    input  logic [smseq_pkg::PCT_W-1:0]             cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [smseq_pkg::SPEED_W-1:0]    s_target_speed,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [1:0]                              m_quadrant,
    output logic [smseq_pkg::STEP_W-1:0]            m_microstep_position,
    output logic [smseq_pkg::DUTY_W-1:0]            m_duty_a,
    output logic [smseq_pkg::DUTY_W-1:0]            m_decay_start_a,
    output logic [smseq_pkg::DUTY_W-1:0]            m_decay_end_a,
    output logic                                    m_fast_decay_a,
    output logic [smseq_pkg::DUTY_W-1:0]            m_duty_b,
    output logic [smseq_pkg::DUTY_W-1:0]            m_decay_start_b,
    output logic [smseq_pkg::DUTY_W-1:0]            m_decay_end_b,
    output logic                                    m_fast_decay_b
);

    localparam int STEP_W  = smseq_pkg::STEP_W;
    localparam int POS_W   = smseq_pkg::POS_W;
    localparam int TBL_W   = smseq_pkg::TBL_W;
    localparam int LEVEL_W = smseq_pkg::LEVEL_W;
    localparam int DUTY_W  = smseq_pkg::DUTY_W;
    localparam int PCT_W   = smseq_pkg::PCT_W;
    localparam int INC_W   = smseq_pkg::INC_W;
    localparam int PRESC_W = smseq_pkg::PRESC_W;
    localparam int SPEED_W = smseq_pkg::SPEED_W;
    localparam int PROD_W  = smseq_pkg::PROD_W;
    localparam int SCALE_W = PROD_W + smseq_pkg::DIV100_MUL_W;

    // configuration
    logic [PCT_W-1:0]   pct_sine_reg, pct_cos_reg;
    logic [PCT_W-1:0]   cfg_pct;

    // sequencing state
    logic [STEP_W-1:0]  step_index_reg, step_index_next;
    logic [PRESC_W-1:0] tick_presc_reg, tick_presc_next;
    logic [INC_W-1:0]   active_inc_reg, active_inc_next;
    logic [PRESC_W-1:0] active_presc_reg, active_presc_next;
    logic [INC_W-1:0]   pending_inc_reg, pending_inc_next;
    logic [PRESC_W-1:0] pending_presc_reg, pending_presc_next;
    logic [LEVEL_W-1:0] speed_mag_reg, speed_mag_next;
    logic               forward_reg, forward_next;

    // leg windows: legs 0/1 serve phase a, legs 2/3 serve phase b
    logic [DUTY_W-1:0]  leg_start_a_reg [2];
    logic [PROD_W-1:0]  leg_prod_a_reg  [2];
    logic [DUTY_W-1:0]  leg_start_b_reg [2];
    logic [PROD_W-1:0]  leg_prod_b_reg  [2];
    logic [1:0]         leg_written_a_reg, leg_written_b_reg;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         quadrant_reg;
    logic [STEP_W-1:0]  position_reg;
    logic [DUTY_W-1:0]  duty_a_reg, start_a_reg, end_a_reg;
    logic [DUTY_W-1:0]  duty_b_reg, start_b_reg, end_b_reg;
    logic               fast_a_reg, fast_b_reg;

    logic               s_accept;
    logic [1:0]         quad;
    logic [POS_W-1:0]   pos;
    logic [TBL_W-1:0]   ti_sum, ti;
    logic [DUTY_W-1:0]  sine_val, cos_val;
    logic               odd;
    logic               sel_a, sel_b;
    logic [DUTY_W-1:0]  duty_a, duty_b;
    logic [PCT_W-1:0]   pct_a, pct_b;
    logic [PROD_W-1:0]  prod_a, prod_b;
    logic               fast_a, fast_b;
    logic [DUTY_W-1:0]  rd_start_a, rd_start_b;
    logic [SCALE_W-1:0] scaled_a, scaled_b;
    logic [DUTY_W:0]    quot_a, quot_b;
    logic [DUTY_W:0]    end_sum_a, end_sum_b;
    logic [DUTY_W-1:0]  end_a, end_b;

    logic [PRESC_W-1:0] tick_inc;
    logic [STEP_W:0]    fwd_sum;
    logic [INC_W-1:0]   level_inc;
    logic               speed_neg;
    logic [SPEED_W-1:0] speed_abs;
    logic [LEVEL_W-1:0] speed_sat;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = !m_valid_reg || m_ready;

    assign cfg_pct = (cfg_wdata > PCT_W'(smseq_pkg::PERCENT_FULL))
                   ? PCT_W'(smseq_pkg::PERCENT_FULL) : cfg_wdata;

    // table lookup one increment ahead, saturated at the quarter
    assign quad   = 2'(step_index_reg >> POS_W);
    assign pos    = step_index_reg[POS_W-1:0];
    assign ti_sum = TBL_W'(pos) + TBL_W'(active_inc_reg);
    assign ti     = (ti_sum > TBL_W'(smseq_pkg::MICROSTEPS))
                  ? TBL_W'(smseq_pkg::MICROSTEPS) : ti_sum;
    assign sine_val = smseq_pkg::SINE_TABLE[ti];
    assign cos_val  = smseq_pkg::SINE_TABLE[TBL_W'(smseq_pkg::MICROSTEPS) - ti];
    assign odd      = quad[0];

    assign sel_a  = ~quad[1];
    assign sel_b  = ~(quad[0] ^ quad[1]);
    assign duty_a = odd ? cos_val : sine_val;
    assign duty_b = odd ? sine_val : cos_val;
    assign pct_a  = odd ? pct_cos_reg : pct_sine_reg;
    assign pct_b  = odd ? pct_sine_reg : pct_cos_reg;

    assign prod_a = PROD_W'(DUTY_W'(smseq_pkg::PWM_PERIOD) - duty_a) * PROD_W'(pct_a);
    assign prod_b = PROD_W'(DUTY_W'(smseq_pkg::PWM_PERIOD) - duty_b) * PROD_W'(pct_b);

    assign fast_a = (DUTY_W+1)'(duty_a) + (DUTY_W+1)'(smseq_pkg::FAST_MARGIN)
                    < (DUTY_W+1)'(smseq_pkg::PWM_PERIOD);
    assign fast_b = (DUTY_W+1)'(duty_b) + (DUTY_W+1)'(smseq_pkg::FAST_MARGIN)
                    < (DUTY_W+1)'(smseq_pkg::PWM_PERIOD);

    // previous window of each leg, end rebuilt from the stored product
    assign rd_start_a = leg_written_a_reg[sel_a] ? leg_start_a_reg[sel_a] : '0;
    assign rd_start_b = leg_written_b_reg[sel_b] ? leg_start_b_reg[sel_b] : '0;
    assign scaled_a   = SCALE_W'(leg_prod_a_reg[sel_a]) * SCALE_W'(smseq_pkg::DIV100_MUL);
    assign scaled_b   = SCALE_W'(leg_prod_b_reg[sel_b]) * SCALE_W'(smseq_pkg::DIV100_MUL);
    assign quot_a     = (DUTY_W+1)'(scaled_a >> smseq_pkg::DIV100_SHIFT);
    assign quot_b     = (DUTY_W+1)'(scaled_b >> smseq_pkg::DIV100_SHIFT);
    assign end_sum_a  = (DUTY_W+1)'(rd_start_a) + quot_a
                      + (DUTY_W+1)'(smseq_pkg::END_OFFSET);
    assign end_sum_b  = (DUTY_W+1)'(rd_start_b) + quot_b
                      + (DUTY_W+1)'(smseq_pkg::END_OFFSET);
    assign end_a      = leg_written_a_reg[sel_a] ? end_sum_a[DUTY_W-1:0] : '0;
    assign end_b      = leg_written_b_reg[sel_b] ? end_sum_b[DUTY_W-1:0] : '0;

    // stepping and speed curve
    assign tick_inc  = tick_presc_reg + PRESC_W'(1);
    assign fwd_sum   = (STEP_W+1)'(step_index_reg) + (STEP_W+1)'(active_inc_reg);
    assign level_inc = (speed_mag_reg == '0) ? '0
                     : (speed_mag_reg < LEVEL_W'(smseq_pkg::FAST_LEVEL))
                       ? INC_W'(smseq_pkg::START_INC) : INC_W'(smseq_pkg::FAST_INC);
    assign speed_neg = s_target_speed[SPEED_W-1];
    assign speed_abs = speed_neg ? (SPEED_W'(0) - SPEED_W'(s_target_speed))
                                 : SPEED_W'(s_target_speed);
    assign speed_sat = (speed_abs > SPEED_W'(smseq_pkg::SPEED_LEVELS - 1))
                     ? LEVEL_W'(smseq_pkg::SPEED_LEVELS - 1) : LEVEL_W'(speed_abs);

    always_comb begin
        step_index_next    = step_index_reg;
        tick_presc_next    = tick_presc_reg;
        active_inc_next    = active_inc_reg;
        active_presc_next  = active_presc_reg;
        pending_inc_next   = pending_inc_reg;
        pending_presc_next = pending_presc_reg;
        speed_mag_next     = speed_mag_reg;
        forward_next       = forward_reg;
        if (s_accept) begin
            if (tick_inc >= active_presc_reg) begin
                tick_presc_next = '0;
                if (forward_reg) begin
                    if (fwd_sum >= (STEP_W+1)'(smseq_pkg::CYCLE_STEPS)) begin
                        step_index_next   = '0;
                        active_inc_next   = pending_inc_reg;
                        active_presc_next = pending_presc_reg;
                    end else begin
                        step_index_next = fwd_sum[STEP_W-1:0];
                    end
                end else if (step_index_reg < STEP_W'(active_inc_reg)) begin
                    active_inc_next   = pending_inc_reg;
                    active_presc_next = pending_presc_reg;
                    // zero pending increment lands on index 0
                    step_index_next   = STEP_W'((STEP_W+1)'(smseq_pkg::CYCLE_STEPS)
                                                - (STEP_W+1)'(pending_inc_reg));
                end else begin
                    step_index_next = step_index_reg - STEP_W'(active_inc_reg);
                end
            end else begin
                tick_presc_next = tick_inc;
            end
            pending_inc_next   = level_inc;
            pending_presc_next = smseq_pkg::SPEED_PRESCALE[speed_mag_reg];
            if (s_target_speed == '0) begin
                speed_mag_next  = '0;
                active_inc_next = '0;
            end else begin
                if (speed_mag_reg == '0) begin
                    active_inc_next = INC_W'(smseq_pkg::START_INC);
                end
                speed_mag_next = speed_sat;
                forward_next   = !speed_neg;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_sine_reg      <= '0;
            pct_cos_reg       <= PCT_W'(smseq_pkg::RESET_PCT_COS);
            step_index_reg    <= '0;
            tick_presc_reg    <= '0;
            active_inc_reg    <= INC_W'(smseq_pkg::START_INC);
            active_presc_reg  <= PRESC_W'(smseq_pkg::RESET_PRESCALE);
            pending_inc_reg   <= '0;
            pending_presc_reg <= PRESC_W'(smseq_pkg::RESET_PRESCALE);
            speed_mag_reg     <= '0;
            forward_reg       <= 1'b1;
            leg_written_a_reg <= '0;
            leg_written_b_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    smseq_pkg::CFG_DECAY_PCT_SINE:   pct_sine_reg <= cfg_pct;
                    smseq_pkg::CFG_DECAY_PCT_COSINE: pct_cos_reg  <= cfg_pct;
                    default: ;
                endcase
            end
            step_index_reg    <= step_index_next;
            tick_presc_reg    <= tick_presc_next;
            active_inc_reg    <= active_inc_next;
            active_presc_reg  <= active_presc_next;
            pending_inc_reg   <= pending_inc_next;
            pending_presc_reg <= pending_presc_next;
            speed_mag_reg     <= speed_mag_next;
            forward_reg       <= forward_next;
            m_valid_reg       <= m_valid_next;
            if (s_accept) begin
                leg_written_a_reg[sel_a] <= 1'b1;
                leg_written_b_reg[sel_b] <= 1'b1;
            end
        end
        if (s_accept) begin
            leg_start_a_reg[sel_a] <= duty_a;
            leg_prod_a_reg[sel_a]  <= prod_a;
            leg_start_b_reg[sel_b] <= duty_b;
            leg_prod_b_reg[sel_b]  <= prod_b;
            quadrant_reg <= quad;
            position_reg <= step_index_reg;
            duty_a_reg   <= duty_a;
            start_a_reg  <= rd_start_a;
            end_a_reg    <= end_a;
            fast_a_reg   <= fast_a;
            duty_b_reg   <= duty_b;
            start_b_reg  <= rd_start_b;
            end_b_reg    <= end_b;
            fast_b_reg   <= fast_b;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_quadrant           = quadrant_reg;
    assign m_microstep_position = position_reg;
    assign m_duty_a             = duty_a_reg;
    assign m_decay_start_a      = start_a_reg;
    assign m_decay_end_a        = end_a_reg;
    assign m_fast_decay_a       = fast_a_reg;
    assign m_duty_b             = duty_b_reg;
    assign m_decay_start_b      = start_b_reg;
    assign m_decay_end_b        = end_b_reg;
    assign m_fast_decay_b       = fast_b_reg;

`ifndef SYNTHESIS
    a_prescaler_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_presc_reg < active_presc_reg)
        else $error("tick prescaler reached the active prescale");

    a_increment_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        active_inc_reg == '0 || active_inc_reg == INC_W'(smseq_pkg::START_INC)
        || active_inc_reg == INC_W'(smseq_pkg::FAST_INC))
        else $error("active increment off the speed curve");

    a_zero_speed_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_target_speed == '0 |=> active_inc_reg == '0 && speed_mag_reg == '0)
        else $error("zero target speed did not stop stepping");

    a_request_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted request produced no result");
`endif

endmodule
